// File: rtl/f2pcm_pkg.sv
package f2pcm_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_OUTPUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES = 2'd1;

    localparam int CFG_DATA_W       = 4;
    localparam logic       FLOAT_OUTPUT_RST = 1'b0;
    localparam logic [3:0] SAMPLE_BYTES_RST = 4'd2;

    localparam int IN_W   = 32;
    localparam int WORD_W = 64;

    // integer scale factors
    localparam logic [14:0] SCALE_U8  = 15'd127;
    localparam logic [14:0] SCALE_S16 = 15'd32767;

    // binary32 exponent offsets of the scaled products (bias 127 plus 23 fraction bits, plus 8 more for U8)
    localparam logic signed [9:0] OFF_S16 = 10'sd150;
    localparam logic signed [9:0] OFF_U8  = 10'sd158;

    localparam logic [10:0] F64_NORM_ADJ = 11'd896;
    localparam logic [10:0] F64_SUB_ADJ  = 11'd874;

    localparam logic [24:0] S16_MAX = 25'd32767;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [32:0] U8_MID  = 33'h0_8000_0000;

    typedef enum logic [2:0] {
        MODE_F32,
        MODE_F64,
        MODE_U8,
        MODE_S16,
        MODE_S32,
        MODE_ERR
    } t_mode;

    typedef struct packed {
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] man;
        logic [38:0] prod;
        logic [4:0]  lead;
    } t_s1;

    typedef struct packed {
        logic               sign;
        logic               is_nan;
        logic               tiny;
        logic [63:0]        fword;
        logic [24:0]        rsig;
        logic signed [9:0]  rexp;
        logic [30:0]        mag32;
        logic               sat32;
    } t_s2;

    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        tiny;
        logic [63:0] fword;
        logic [32:0] mag;
        logic        sticky;
        logic        sat;
    } t_s3;

endpackage

// File: rtl/f2pcm_mul.sv
module f2pcm_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  f2pcm_pkg::t_mode      i_mode,
    input  logic                  i_valid,
    input  logic [31:0]           i_data,
    output logic                  o_valid,
    output f2pcm_pkg::t_s1        o_data
);

    logic            r_valid;
    f2pcm_pkg::t_s1  r_data;
    f2pcm_pkg::t_s1  n_data;
    logic [23:0]     sig;
    logic [14:0]     scale;

    always_comb begin
        n_data.sign = i_data[31];
        n_data.expo = i_data[30:23];
        n_data.man  = i_data[22:0];
        sig   = {|i_data[30:23], i_data[22:0]};
        scale = (i_mode == f2pcm_pkg::MODE_U8) ? f2pcm_pkg::SCALE_U8 : f2pcm_pkg::SCALE_S16;
        n_data.prod = 39'(sig) * 39'(scale);
        // leading one of a subnormal fraction
        n_data.lead = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (i_data[i]) begin
                n_data.lead = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/f2pcm_rnd.sv
module f2pcm_rnd (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  f2pcm_pkg::t_mode      i_mode,
    input  logic                  i_valid,
    input  f2pcm_pkg::t_s1        i_data,
    output logic                  o_valid,
    output f2pcm_pkg::t_s2        o_data
);

    logic            r_valid;
    f2pcm_pkg::t_s2  r_data;
    f2pcm_pkg::t_s2  n_data;
    logic [38:0]     pp;
    logic            hi;
    logic [23:0]     rs;
    logic            guard;
    logic            sticky;
    logic [22:0]     norm;
    logic [63:0]     f64;
    logic [23:0]     sig;
    logic            is_u8;

    always_comb begin
        sig   = {|i_data.expo, i_data.man};
        is_u8 = (i_mode == f2pcm_pkg::MODE_U8);

        // exact widening to binary64
        norm = i_data.man << (5'd22 - i_data.lead);
        if (i_data.expo == 8'hFF) begin
            f64 = {i_data.sign, 11'h7FF, i_data.man, 29'd0};
            f64[51] = f64[51] | (|i_data.man);
        end else if (i_data.expo == 8'd0) begin
            if (i_data.man == 23'd0) begin
                f64 = {i_data.sign, 63'd0};
            end else begin
                f64 = {i_data.sign, 11'(i_data.lead) + f2pcm_pkg::F64_SUB_ADJ,
                       norm[21:0], 30'd0};
            end
        end else begin
            f64 = {i_data.sign, 11'(i_data.expo) + f2pcm_pkg::F64_NORM_ADJ,
                   i_data.man, 29'd0};
        end

        n_data.sign   = i_data.sign;
        n_data.is_nan = (i_data.expo == 8'hFF) && (i_data.man != 23'd0);
        n_data.tiny   = (i_data.expo == 8'd0);
        n_data.fword  = (i_mode == f2pcm_pkg::MODE_F32) ?
                        {32'd0, i_data.sign, i_data.expo, i_data.man} : f64;

        // round the scaled product to 24 bits, nearest even
        pp = is_u8 ? (i_data.prod << 8) : i_data.prod;
        hi = pp[38];
        if (hi) begin
            rs     = pp[38:15];
            guard  = pp[14];
            sticky = |pp[13:0];
        end else begin
            rs     = pp[37:14];
            guard  = pp[13];
            sticky = |pp[12:0];
        end
        n_data.rsig = {1'b0, rs} + 25'(guard & (sticky | rs[0]));
        n_data.rexp = $signed({2'b00, i_data.expo})
                      - (is_u8 ? f2pcm_pkg::OFF_U8 : f2pcm_pkg::OFF_S16)
                      + (hi ? 10'sd15 : 10'sd14);

        // scaling by 2^31, truncated toward zero for small exponents
        n_data.sat32 = (i_data.expo >= 8'd127);
        if (i_data.expo >= 8'd119) begin
            n_data.mag32 = 31'(sig) << 3'(i_data.expo - 8'd119);
        end else begin
            n_data.mag32 = 31'(sig) >> (8'd119 - i_data.expo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/f2pcm_shf.sv
module f2pcm_shf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  f2pcm_pkg::t_mode      i_mode,
    input  logic                  i_valid,
    input  f2pcm_pkg::t_s2        i_data,
    output logic                  o_valid,
    output f2pcm_pkg::t_s3        o_data
);

    logic               r_valid;
    f2pcm_pkg::t_s3     r_data;
    f2pcm_pkg::t_s3     n_data;
    logic signed [9:0]  k;
    logic [9:0]         nk;
    logic [9:0]         nsh;
    logic [24:0]        v;
    logic [24:0]        part;
    logic [31:0]        m32;

    always_comb begin
        n_data.sign   = i_data.sign;
        n_data.is_nan = i_data.is_nan;
        n_data.tiny   = i_data.tiny;
        n_data.fword  = i_data.fword;
        n_data.mag    = 33'd0;
        n_data.sticky = 1'b0;
        n_data.sat    = 1'b0;

        k    = i_data.rexp + 10'sd24;
        nk   = 10'(-k);
        nsh  = 10'(-i_data.rexp);
        v    = i_data.rsig >> nsh;
        part = i_data.rsig >> nk;
        m32  = i_data.sat32 ? f2pcm_pkg::S32_MAX : {1'b0, i_data.mag32};

        case (i_mode)
            f2pcm_pkg::MODE_U8: begin
                // magnitude of the product in units of 2^-24
                if (k >= 10'sd8) begin
                    n_data.sat = 1'b1;
                end else if (k >= 10'sd0) begin
                    n_data.mag = 33'(i_data.rsig) << k[2:0];
                    n_data.sat = |n_data.mag[32:31];
                end else begin
                    n_data.mag    = 33'(part);
                    n_data.sticky = ((part << nk) != i_data.rsig);
                end
            end
            f2pcm_pkg::MODE_S16: begin
                if (i_data.rexp >= 10'sd0 || v >= f2pcm_pkg::S16_MAX) begin
                    n_data.sat = 1'b1;
                end else begin
                    n_data.mag = 33'(v);
                end
            end
            f2pcm_pkg::MODE_S32: begin
                n_data.mag = {1'b0, i_data.sign ? (32'd0 - m32) : m32};
            end
            default: begin
                n_data.mag = 33'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/f2pcm_fin.sv
module f2pcm_fin (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  f2pcm_pkg::t_mode      i_mode,
    input  logic                  i_valid,
    input  f2pcm_pkg::t_s3        i_data,
    output logic                  o_valid,
    output logic [63:0]           o_word,
    output logic                  o_err
);

    logic         r_valid;
    logic [63:0]  r_word;
    logic         r_err;
    logic [63:0]  n_word;
    logic         n_err;
    logic [32:0]  s;
    logic [32:0]  sr;
    logic [15:0]  v16;

    always_comb begin
        n_word = 64'd0;
        n_err  = 1'b0;

        // 128 plus the product, then round to binary32 precision
        if (i_data.sign) begin
            s = f2pcm_pkg::U8_MID - i_data.mag - 33'(i_data.sticky);
        end else begin
            s = f2pcm_pkg::U8_MID + i_data.mag;
        end
        if (s[31]) begin
            sr = s + (33'(s[7] & ((|s[6:0]) | i_data.sticky | s[8])) << 8);
        end else if (s[30]) begin
            sr = s + (33'(s[6] & ((|s[5:0]) | i_data.sticky | s[7])) << 7);
        end else begin
            sr = s;
        end

        v16 = i_data.sat ? 16'(f2pcm_pkg::S16_MAX) : i_data.mag[15:0];

        case (i_mode)
            f2pcm_pkg::MODE_F32, f2pcm_pkg::MODE_F64: begin
                n_word = i_data.fword;
            end
            f2pcm_pkg::MODE_U8: begin
                if (i_data.is_nan) begin
                    n_word = 64'd0;
                end else if (i_data.tiny) begin
                    n_word = 64'd128;
                end else if (i_data.sat) begin
                    n_word = i_data.sign ? 64'd0 : 64'd255;
                end else if (sr[32]) begin
                    n_word = 64'd255;
                end else begin
                    n_word = {56'd0, sr[31:24]};
                end
            end
            f2pcm_pkg::MODE_S16: begin
                if (!i_data.is_nan && !i_data.tiny) begin
                    n_word = {48'd0, i_data.sign ? (16'd0 - v16) : v16};
                end
            end
            f2pcm_pkg::MODE_S32: begin
                if (!i_data.is_nan) begin
                    n_word = {32'd0, i_data.mag[31:0]};
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
            r_err  <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_err   = r_err;

endmodule

// File: rtl/float_to_pcm_sample_converter_top.sv
// Converts one binary32 audio sample per clock, while the output is not stalled, into the
// configured output format: float pass-through, exact widening to binary64, or 8-bit offset,
// 16-bit or 32-bit signed PCM with saturation and truncation toward zero; NaN gives zero in
// the PCM formats and an unsupported format gives a zero word with tuser set. The accepting
// edge loads the first of the four stage registers (multiply, round/widen, align,
// add/round/clamp), and output valid rises when the sample is in the last of them; a new
// sample is taken every cycle unless the output stalls, which freezes all four stages together.
// Write configuration only while no sample is in flight.
module float_to_pcm_sample_converter_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // [31:0] sample_bits
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,   // [63:0] pcm_word
    output logic         o_m_axis_tuser,   // [0] format_error
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [f2pcm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [f2pcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_float_output;
    logic [3:0]        r_sample_bytes;
    f2pcm_pkg::t_mode  mode;
    logic              en;
    logic              v1;
    logic              v2;
    logic              v3;
    f2pcm_pkg::t_s1    d1;
    f2pcm_pkg::t_s2    d2;
    f2pcm_pkg::t_s3    d3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float_output <= f2pcm_pkg::FLOAT_OUTPUT_RST;
            r_sample_bytes <= f2pcm_pkg::SAMPLE_BYTES_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                f2pcm_pkg::CFG_FLOAT_OUTPUT: r_float_output <= i_cfg_data[0];
                f2pcm_pkg::CFG_SAMPLE_BYTES: r_sample_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_float_output) begin
            case (r_sample_bytes)
                4'd4:    mode = f2pcm_pkg::MODE_F32;
                4'd8:    mode = f2pcm_pkg::MODE_F64;
                default: mode = f2pcm_pkg::MODE_ERR;
            endcase
        end else begin
            case (r_sample_bytes)
                4'd1:    mode = f2pcm_pkg::MODE_U8;
                4'd2:    mode = f2pcm_pkg::MODE_S16;
                4'd4:    mode = f2pcm_pkg::MODE_S32;
                default: mode = f2pcm_pkg::MODE_ERR;
            endcase
        end
    end

    // whole pipeline advances when the output register is free
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready     = 1'b1;

    f2pcm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (mode),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_valid (v1),
        .o_data  (d1)
    );

    f2pcm_rnd u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (mode),
        .i_valid (v1),
        .i_data  (d1),
        .o_valid (v2),
        .o_data  (d2)
    );

    f2pcm_shf u_shf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (mode),
        .i_valid (v2),
        .i_data  (d2),
        .o_valid (v3),
        .o_data  (d3)
    );

    f2pcm_fin u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mode  (mode),
        .i_valid (v3),
        .i_data  (d3),
        .o_valid (o_m_axis_tvalid),
        .o_word  (o_m_axis_tdata),
        .o_err   (o_m_axis_tuser)
    );

endmodule
